// ===== design/ffd_pkg.sv =====
// shared constants, types and register codes for the fractional feedback delay
`timescale 1ns / 1ps
`default_nettype none

package ffd_pkg;

    // store geometry and number formats
    localparam int DEPTH       = 65536;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int LEN_BITS    = $clog2(DEPTH) + 1;
    localparam int FRAC_BITS   = 8;
    localparam int SAMPLE_BITS = 24;
    localparam int GAIN_BITS   = 16;
    localparam int GAIN_SHIFT  = GAIN_BITS - 1;
    localparam int DELAY_BITS  = 24;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LENGTH = 2'd2;

    // register reset values
    localparam logic [DELAY_BITS-1:0]       DELAY_RESET = '0;
    localparam logic signed [GAIN_BITS-1:0] GAIN_RESET  = 16'sd16384;
    localparam logic [LEN_BITS-1:0]         LEN_RESET   = LEN_BITS'(DEPTH);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // access bundle from the sequencer to the delay store
    typedef struct packed {
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr_a;
        logic [ADDR_BITS-1:0] rd_addr_b;
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        sample_t              wr_data;
    } store_req_t;

endpackage

`default_nettype wire

// ===== design/ffd_in_if.sv =====
// input word channel carrying one audio sample
`timescale 1ns / 1ps
`default_nettype none

interface ffd_in_if;
    import ffd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== design/ffd_out_if.sv =====
// output word channel carrying one delayed sample
`timescale 1ns / 1ps
`default_nettype none

interface ffd_out_if;
    import ffd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== design/ffd_store.sv =====
// ring delay store: one write port, two registered read ports, fill count for reset zeros
`timescale 1ns / 1ps
`default_nettype none

module ffd_store (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ffd_pkg::store_req_t req,
    output ffd_pkg::sample_t         rd_data_a,
    output ffd_pkg::sample_t         rd_data_b
);
    import ffd_pkg::*;

    sample_t             mem [DEPTH];
    sample_t             rd_a_reg;
    sample_t             rd_b_reg;
    logic                ok_a_reg;
    logic                ok_b_reg;
    logic                ok_a_next;
    logic                ok_b_next;
    logic [LEN_BITS-1:0] fill_reg;
    logic [LEN_BITS-1:0] fill_next;

    // entries at or above the fill count were never written and read as zero
    always_comb
    begin
        ok_a_next = {1'b0, req.rd_addr_a} < fill_reg;
        ok_b_next = {1'b0, req.rd_addr_b} < fill_reg;
        fill_next = fill_reg;
        if (req.wr_en && ({1'b0, req.wr_addr} == fill_reg))
        begin
            fill_next = fill_reg + LEN_BITS'(1);
        end
    end

    // memory array
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_a_reg <= mem[req.rd_addr_a];
            rd_b_reg <= mem[req.rd_addr_b];
        end
    end

    // fill count and read qualifiers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ok_a_reg <= 1'b0;
            ok_b_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (req.rd_en)
            begin
                ok_a_reg <= ok_a_next;
                ok_b_reg <= ok_b_next;
            end
        end
    end

    assign rd_data_a = ok_a_reg ? rd_a_reg : '0;
    assign rd_data_b = ok_b_reg ? rd_b_reg : '0;

endmodule

`default_nettype wire

// ===== design/fractional_feedback_delay.sv =====
// top level: feedback comb delay with a linearly interpolated fractional read tap
`timescale 1ns / 1ps
`default_nettype none

// One input word is taken at a time. Once it is accepted, the block forms the
// fixed-point read position, reads both neighboring entries through the two
// read ports of the delay store, interpolates, applies the feedback gain and
// finally writes the store and loads the output register. The next word is
// taken only after the write-back, when the sequencer is idle again, so a new
// word cannot enter before the last one is through. A result that is not yet
// taken holds the write-back step until the output register is free, which
// stretches the item by the stall. The store comes out of reset without a
// clearing pass: a fill count makes every entry that was never written read as
// zero. Register writes take effect at once; a buffer length clamps to
// 1..65536, and a write position that lies beyond the length in use restarts
// at 0 when the next word is processed.
module fractional_feedback_delay (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    ffd_in_if.sink                                  in_ch,
    ffd_out_if.source                               out_ch,
    input  wire logic                               cfg_we,
    input  wire logic [ffd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [ffd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import ffd_pkg::*;

    localparam int TOT_BITS  = LEN_BITS + FRAC_BITS;
    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int IP_BITS   = DIFF_BITS + FRAC_BITS + 1;
    localparam int FBP_BITS  = SAMPLE_BITS + GAIN_BITS;
    localparam int FB_BITS   = FBP_BITS - GAIN_SHIFT;
    localparam int SUM_BITS  = FB_BITS + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ADDR  = 6'b000010,
        S_READ  = 6'b000100,
        S_MIX   = 6'b001000,
        S_MUL   = 6'b010000,
        S_WRITE = 6'b100000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;

    logic [DELAY_BITS-1:0]         delay_reg;
    logic signed [GAIN_BITS-1:0]   gain_reg;
    logic [LEN_BITS-1:0]           len_reg;
    logic [LEN_BITS-1:0]           len_cfg;
    logic [ADDR_BITS-1:0]          pos_reg;
    logic [ADDR_BITS-1:0]          pos_eff;
    logic [ADDR_BITS-1:0]          pos_step;
    logic [LEN_BITS-1:0]           pos_inc;

    sample_t                       x_reg;
    logic [TOT_BITS-1:0]           total_reg;
    logic [TOT_BITS-1:0]           total_next;
    logic [TOT_BITS-1:0]           len_fix;
    logic [TOT_BITS-1:0]           d_ext;
    logic [TOT_BITS-1:0]           d_clamp;

    logic [LEN_BITS-1:0]           left_raw;
    logic [LEN_BITS-1:0]           left_w;
    logic [LEN_BITS-1:0]           right_inc;
    logic [LEN_BITS-1:0]           right_w;

    sample_t                       rd_a;
    sample_t                       rd_b;
    logic signed [DIFF_BITS-1:0]   diff;
    logic signed [IP_BITS-1:0]     ip_prod;
    logic signed [IP_BITS-1:0]     ip_step;
    sample_t                       delayed_reg;
    sample_t                       delayed_next;

    logic signed [FBP_BITS-1:0]    fbp_reg;
    logic signed [FB_BITS-1:0]     fb;
    logic signed [SUM_BITS-1:0]    sum;
    sample_t                       stored;

    logic                          out_free;
    logic                          out_valid_reg;
    sample_t                       sample_out_reg;
    store_req_t                    store_req;

    // delay store
    ffd_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (store_req),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // clamped length from a configuration word
    always_comb
    begin
        len_cfg = cfg_data[LEN_BITS-1:0];
        if (len_cfg == '0)
        begin
            len_cfg = LEN_BITS'(1);
        end
        else if (len_cfg > LEN_BITS'(DEPTH))
        begin
            len_cfg = LEN_BITS'(DEPTH);
        end
    end

    // read position: write position minus clamped delay, one length added
    always_comb
    begin
        pos_eff    = ({1'b0, pos_reg} >= len_reg) ? '0 : pos_reg;
        len_fix    = {len_reg, {FRAC_BITS{1'b0}}};
        d_ext      = TOT_BITS'(delay_reg);
        d_clamp    = (d_ext > len_fix) ? len_fix : d_ext;
        total_next = {1'b0, pos_eff, {FRAC_BITS{1'b0}}} + len_fix - d_clamp;
    end

    // wrap the two neighbor indices into the ring
    always_comb
    begin
        left_raw  = total_reg[TOT_BITS-1:FRAC_BITS];
        left_w    = (left_raw >= len_reg) ? (left_raw - len_reg) : left_raw;
        right_inc = left_w + LEN_BITS'(1);
        right_w   = (right_inc >= len_reg) ? '0 : right_inc;
    end

    // linear interpolation, floor of the scaled difference
    always_comb
    begin
        diff         = DIFF_BITS'(rd_b) - DIFF_BITS'(rd_a);
        ip_prod      = IP_BITS'(diff) * IP_BITS'($signed({1'b0, total_reg[FRAC_BITS-1:0]}));
        ip_step      = ip_prod >>> FRAC_BITS;
        delayed_next = rd_a + ip_step[SAMPLE_BITS-1:0];
    end

    // feedback term and saturated store value
    always_comb
    begin
        fb  = fbp_reg[FBP_BITS-1:GAIN_SHIFT];
        sum = SUM_BITS'(x_reg) + SUM_BITS'(fb);
        if (sum[SUM_BITS-1:SAMPLE_BITS-1] == '0 || sum[SUM_BITS-1:SAMPLE_BITS-1] == '1)
        begin
            stored = sum[SAMPLE_BITS-1:0];
        end
        else if (sum[SUM_BITS-1])
        begin
            stored = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            stored = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // next write position
    always_comb
    begin
        pos_inc  = {1'b0, pos_reg} + LEN_BITS'(1);
        pos_step = (pos_inc >= len_reg) ? '0 : pos_inc[ADDR_BITS-1:0];
    end

    assign out_free = !out_valid_reg || out_ch.ready;

    // store access
    always_comb
    begin
        store_req.rd_en     = (state_reg == S_READ);
        store_req.rd_addr_a = left_w[ADDR_BITS-1:0];
        store_req.rd_addr_b = right_w[ADDR_BITS-1:0];
        store_req.wr_en     = (state_reg == S_WRITE) && out_free;
        store_req.wr_addr   = pos_reg;
        store_req.wr_data   = stored;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:  state_next = S_READ;
            S_READ:  state_next = S_MIX;
            S_MIX:   state_next = S_MUL;
            S_MUL:   state_next = S_WRITE;
            S_WRITE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            delay_reg     <= DELAY_RESET;
            gain_reg      <= GAIN_RESET;
            len_reg       <= LEN_RESET;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DELAY:  delay_reg <= cfg_data[DELAY_BITS-1:0];
                    CFG_GAIN:   gain_reg <= $signed(cfg_data[GAIN_BITS-1:0]);
                    CFG_LENGTH: len_reg <= len_cfg;
                    default: ;
                endcase
            end
            // position restart is settled once the word starts
            if (state_reg == S_ADDR)
            begin
                pos_reg <= pos_eff;
            end
            if (store_req.wr_en)
            begin
                pos_reg       <= pos_step;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            x_reg <= in_ch.sample_in;
        end
        if (state_reg == S_ADDR)
        begin
            total_reg <= total_next;
        end
        if (state_reg == S_MIX)
        begin
            delayed_reg <= delayed_next;
        end
        if (state_reg == S_MUL)
        begin
            fbp_reg <= FBP_BITS'(delayed_reg) * FBP_BITS'(gain_reg);
        end
        if (store_req.wr_en)
        begin
            sample_out_reg <= delayed_reg;
        end
    end

    assign in_ch.ready       = (state_reg == S_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.sample_out = sample_out_reg;

    // write-back address always lies inside the ring in use
    assert property (@(posedge clk) disable iff (!rst_n)
        store_req.wr_en |-> ({1'b0, pos_reg} < len_reg))
        else $error("write position beyond ring length");

    // ring length stays inside the clamped range
    assert property (@(posedge clk) disable iff (!rst_n)
        len_reg != '0 && len_reg <= LEN_BITS'(DEPTH))
        else $error("ring length out of range");

    // a new result only appears after the write-back step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_WRITE))
        else $error("result without write-back");

    // a store write never overwrites a result that is still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        store_req.wr_en |-> (!out_valid_reg || out_ch.ready))
        else $error("store write while output blocked");

endmodule

`default_nettype wire

// ===== test/fractional_feedback_delay_test.sv =====
// self-checking testbench for the fractional feedback delay
`timescale 1ns / 1ps

import ffd_pkg::*;

// predicts each delayed sample from a private copy of the ring store and the registers
class echo_predictor;
    sample_t                       ring [0:DEPTH-1];
    longint                        head;
    logic [DELAY_BITS-1:0]         delay_q8;
    logic signed [GAIN_BITS-1:0]   gain;
    logic [LEN_BITS-1:0]           length;
    sample_t                       pending_echoes [$];
    int                            errors;

    function new();
        foreach (ring[i])
            ring[i] = '0;
        head     = 0;
        delay_q8 = DELAY_RESET;
        gain     = GAIN_RESET;
        length   = LEN_RESET;
        errors   = 0;
    endfunction

    // register write as the block sees it; a spare index changes nothing
    function void set_reg(input logic [CFG_IDX_BITS-1:0] idx,
                          input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_DELAY:  delay_q8 = data[DELAY_BITS-1:0];
            CFG_GAIN:   gain = data[GAIN_BITS-1:0];
            CFG_LENGTH: length = data[LEN_BITS-1:0];
            default:    ;
        endcase
    endfunction

    // one accepted word: interpolated read, feedback write, position advance
    function void take_sample(input sample_t x);
        longint len;
        longint span;
        longint d;
        longint total;
        longint lft;
        longint rgt;
        longint frac;
        longint a;
        longint b;
        longint mixed;
        longint fb;
        longint sum;
        longint hi;
        longint lo;
        len = length;
        if (len < 1)
            len = 1;
        if (len > DEPTH)
            len = DEPTH;
        if (head >= len)
            head = 0;
        span = len << FRAC_BITS;
        d = delay_q8;
        if (d > span)
            d = span;
        total = (head << FRAC_BITS) + span - d;
        lft = (total >> FRAC_BITS) % len;
        frac = total & ((longint'(1) << FRAC_BITS) - 1);
        rgt = lft + 1;
        if (rgt >= len)
            rgt = 0;
        a = ring[lft];
        b = ring[rgt];
        mixed = a + (((b - a) * frac) >>> FRAC_BITS);
        fb = (mixed * longint'(gain)) >>> GAIN_SHIFT;
        // saturate the stored word to the sample width
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        sum = longint'(x) + fb;
        if (sum > hi)
            sum = hi;
        if (sum < lo)
            sum = lo;
        ring[head] = sample_t'(sum);
        head = head + 1;
        if (head >= len)
            head = 0;
        pending_echoes.push_back(sample_t'(mixed));
    endfunction

    // compare one output word with the oldest prediction
    function void check_echo(input sample_t y);
        sample_t want;
        if (pending_echoes.size() == 0)
        begin
            $error("sample_out: no word expected, got %0d", y);
            errors++;
        end
        else
        begin
            want = pending_echoes.pop_front();
            if (y !== want)
            begin
                $error("sample_out: expected %0d, got %0d", want, y);
                errors++;
            end
        end
    endfunction
endclass

module fractional_feedback_delay_test;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam sample_t SAMPLE_MAX = 24'sh7FFFFF;
    localparam sample_t SAMPLE_MIN = 24'sh800000;
    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // driven inputs, all known from time zero
    logic                      src_valid = 1'b0;
    sample_t                   src_sample = '0;
    logic                      sink_ready = 1'b1;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    bit                        quiet = 1'b0;
    int                        stall_left = 0;
    int unsigned               cycle_count = 0;

    echo_predictor book = new();

    ffd_in_if  in_ch ();
    ffd_out_if out_ch ();

    assign in_ch.valid     = src_valid;
    assign in_ch.sample_in = src_sample;
    assign out_ch.ready    = sink_ready;

    fractional_feedback_delay DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // gap length: mostly none, some short, a few long
    function automatic int next_gap();
        int r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side back-pressure
    always @(negedge clk)
    begin
        if (!rst_n || quiet)
            sink_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            sink_ready <= 1'b1;
            stall_left <= next_gap();
        end
    end

    // output word monitor
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            book.check_echo(out_ch.sample_out);
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count == CYCLE_LIMIT);
        $display("fractional_feedback_delay: mismatch");
        $finish;
    end

    // offer one word after a random gap and hold it until taken
    task automatic send_sample(input sample_t s);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            src_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        src_valid  <= 1'b1;
        src_sample <= s;
        do
            @(posedge clk);
        while (!in_ch.ready);
        book.take_sample(s);
    endtask

    // drop valid after the last word of a burst, then wait for every echo
    task automatic drain_echoes();
        @(negedge clk);
        src_valid <= 1'b0;
        while (book.pending_echoes.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        book.set_reg(idx, data);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int                      random_sent;
        int                      pick;
        int                      batch;
        longint                  len_pick;
        longint                  eff_len;
        longint                  span;
        logic [DELAY_BITS-1:0]   delay_pick;
        logic [GAIN_BITS-1:0]    gain_pick;
        sample_t                 s;

        random_sent = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: zero delay reads the entry about to be overwritten
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sd1);
        drain_echoes();

        // short ring, one-and-a-half-sample delay, gain just under one
        write_reg(CFG_LENGTH, 24'd4);
        write_reg(CFG_DELAY, 24'h000180);
        write_reg(CFG_GAIN, {8'h00, 16'h7FFF});
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MIN);
        send_sample(24'sh123456);
        send_sample(-24'sd1);
        drain_echoes();

        // zero length acts as one, position restarts, delay clamped, gain of minus one
        write_reg(CFG_LENGTH, 24'd0);
        write_reg(CFG_DELAY, 24'hFFFFFF);
        write_reg(CFG_GAIN, {8'h00, 16'h8000});
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(24'sd5);
        drain_echoes();

        // length above the store clamps to full depth; spare index is ignored
        write_reg(CFG_LENGTH, 24'h01FFFF);
        write_reg(CFG_DELAY, 24'h000080);
        write_reg(CFG_GAIN, 24'h000000);
        write_reg(CFG_SPARE, 24'hFFFFFF);
        send_sample(sample_t'($urandom));
        send_sample(sample_t'($urandom));
        send_sample(SAMPLE_MIN);
        send_sample(SAMPLE_MAX);
        drain_echoes();

        // random phases, each with a fresh setting
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0:       len_pick = 0;
                1:       len_pick = 1;
                2:       len_pick = DEPTH;
                3:       len_pick = $urandom_range(DEPTH + 1, 131071);
                4:       len_pick = $urandom_range(0, 131071);
                default: len_pick = $urandom_range(2, 48);
            endcase
            eff_len = len_pick;
            if (eff_len < 1)
                eff_len = 1;
            if (eff_len > DEPTH)
                eff_len = DEPTH;
            span = eff_len << FRAC_BITS;
            if (span > 24'hFFFFFF)
                span = 24'hFFFFFF;

            pick = $urandom_range(0, 7);
            case (pick)
                0:       delay_pick = '0;
                1:       delay_pick = 24'hFFFFFF;
                2:       delay_pick = DELAY_BITS'($urandom);
                3:       delay_pick = DELAY_BITS'(span);
                default: delay_pick = DELAY_BITS'($urandom_range(0, int'(span)));
            endcase

            pick = $urandom_range(0, 7);
            case (pick)
                0:       gain_pick = 16'h7FFF;
                1:       gain_pick = 16'h8000;
                2:       gain_pick = 16'h0000;
                default: gain_pick = GAIN_BITS'($urandom);
            endcase

            write_reg(CFG_LENGTH, CFG_DATA_BITS'(len_pick));
            write_reg(CFG_DELAY, delay_pick);
            write_reg(CFG_GAIN, {8'h00, gain_pick});
            if ($urandom_range(0, 5) == 0)
                write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));

            quiet = ($urandom_range(0, 3) == 0);
            batch = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(5, 30);
            repeat (batch)
            begin
                pick = $urandom_range(0, 9);
                case (pick)
                    0:       s = SAMPLE_MAX;
                    1:       s = SAMPLE_MIN;
                    2:       s = sample_t'($urandom_range(0, 31)) - 24'sd16;
                    default: s = sample_t'($urandom);
                endcase
                send_sample(s);
                random_sent++;
            end
            drain_echoes();
            quiet = 1'b0;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.pending_echoes.size() != 0)
        begin
            $error("sample_out: %0d words never arrived", book.pending_echoes.size());
            book.errors++;
        end
        if (book.errors == 0)
            $display("fractional_feedback_delay: match");
        else
            $display("fractional_feedback_delay: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ffd_pkg.sv
design/ffd_in_if.sv
design/ffd_out_if.sv
design/ffd_store.sv
design/fractional_feedback_delay.sv
test/fractional_feedback_delay_test.sv
